@@ sv/ssspd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssspd_pkg
// Shared constants and types for the dense single-source shortest path block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssspd_pkg;

  localparam int unsigned VERT_W       = 5;
  localparam int unsigned MAX_VERTICES = 2 ** VERT_W;
  localparam int unsigned CNT_W        = VERT_W + 1;
  localparam int unsigned CFG_W        = 6;
  localparam int unsigned WEIGHT_W     = 12;
  localparam int unsigned DIST_W       = 15;
  localparam int unsigned MAT_AW       = 2 * VERT_W;
  localparam int unsigned MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;

  localparam logic [DIST_W-1:0] INF_DIST      = DIST_W'(32767);
  localparam logic [CFG_W-1:0]  VCOUNT_RESET  = CFG_W'(6);

  typedef struct packed {
    logic              visited;
    logic [DIST_W-1:0] distance;
    logic [VERT_W-1:0] pred;
  } vtab_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_INIT  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_RELAX = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

endpackage

`default_nettype wire

@@ sv/single_source_shortest_path_dense_top.sv @@
// An edge write goes into the weight matrix directly; in a run for n active vertices,
//   each init, scan, relax and output pass reads one entry per vertex through the
//   registered RAM read.
// Throughput: one item at a time; results stream one per cycle at the end of a run.
// Reset: asynchronous, active low; afterward a clearing pass zeroes the weight
//   matrix one entry per cycle with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
// single_source_shortest_path_dense_top
// Dijkstra shortest paths over an adjacency matrix held in on-chip RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module single_source_shortest_path_dense_top
  import ssspd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                command_i,
  input  wire logic [VERT_W-1:0]   from_vertex_i,
  input  wire logic [VERT_W-1:0]   to_vertex_i,
  input  wire logic [WEIGHT_W-1:0] edge_weight_i,
  input  wire logic [VERT_W-1:0]   source_vertex_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  output logic                     result_valid_o,
  output logic [VERT_W-1:0]        vertex_index_o,
  output logic [DIST_W-1:0]        distance_o,
  output logic [VERT_W-1:0]        predecessor_o,
  output logic                     last_o
);

  state_e              state_q, state_d;
  logic [MAT_AW-1:0]   clr_q, clr_d;
  logic [CFG_W-1:0]    cfg_q;
  logic [CNT_W-1:0]    n_q, n_d, n_eff;
  logic [VERT_W-1:0]   src_q, src_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                p_vld_q, p_vld_d;
  logic [VERT_W-1:0]   p_idx_q, p_idx_d;
  logic [DIST_W-1:0]   best_q, best_d;
  logic [VERT_W-1:0]   cur_q, cur_d;
  logic [VERT_W-1:0]   cur_pred_q, cur_pred_d;
  logic                found_q, found_d;
  logic [CNT_W-1:0]    step_q, step_d;

  logic                res_vld_q, res_vld_d;
  logic [VERT_W-1:0]   res_idx_q, res_idx_d;
  logic [DIST_W-1:0]   res_dist_q, res_dist_d;
  logic [VERT_W-1:0]   res_pred_q, res_pred_d;
  logic                res_last_q, res_last_d;

  logic                mat_we;
  logic [MAT_AW-1:0]   mat_waddr, mat_raddr;
  logic [WEIGHT_W-1:0] mat_wdata, mat_rdata;
  logic                vt_we;
  logic [VERT_W-1:0]   vt_waddr, vt_raddr;
  vtab_t               vt_wdata, vt_rdata;

  logic                iss_act, phase_done;
  logic [DIST_W:0]     sum;
  logic [DIST_W-1:0]   sum_sat;

  ssspd_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAT_DEPTH)
  ) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (mat_wdata),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  ssspd_ram #(
    .WIDTH ($bits(vtab_t)),
    .DEPTH (MAX_VERTICES)
  ) u_vtab_ram (
    .clk_i   (clk_i),
    .we_i    (vt_we),
    .waddr_i (vt_waddr),
    .wdata_i (vt_wdata),
    .raddr_i (vt_raddr),
    .rdata_o (vt_rdata)
  );

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign iss_act     = (idx_q < n_q);
  assign phase_done  = !iss_act && !p_vld_q;

  assign n_eff = (cfg_q == '0) ? CNT_W'(1) :
                 (CNT_W'(cfg_q) > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) :
                 CNT_W'(cfg_q);

  assign sum     = {1'b0, best_q} + (DIST_W + 1)'(mat_rdata);
  assign sum_sat = (sum >= {1'b0, INF_DIST}) ? INF_DIST : sum[DIST_W-1:0];

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    n_d        = n_q;
    src_d      = src_q;
    idx_d      = idx_q;
    p_vld_d    = 1'b0;
    p_idx_d    = idx_q[VERT_W-1:0];
    best_d     = best_q;
    cur_d      = cur_q;
    cur_pred_d = cur_pred_q;
    found_d    = found_q;
    step_d     = step_q;
    res_vld_d  = 1'b0;
    res_idx_d  = res_idx_q;
    res_dist_d = res_dist_q;
    res_pred_d = res_pred_q;
    res_last_d = res_last_q;
    mat_we     = 1'b0;
    mat_waddr  = clr_q;
    mat_wdata  = '0;
    mat_raddr  = {src_q, idx_q[VERT_W-1:0]};
    vt_we      = 1'b0;
    vt_waddr   = p_idx_q;
    vt_wdata   = '0;
    vt_raddr   = idx_q[VERT_W-1:0];

    case (state_q)
      ST_CLEAR: begin
        mat_we = 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + MAT_AW'(1);
        end
      end
      ST_IDLE: begin
        idx_d = '0;
        if (start) begin
          if (!command_i) begin
            mat_we    = 1'b1;
            mat_waddr = {from_vertex_i, to_vertex_i};
            mat_wdata = edge_weight_i;
          end else if (CNT_W'(source_vertex_i) < n_eff) begin
            n_d     = n_eff;
            src_d   = source_vertex_i;
            step_d  = '0;
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        if (iss_act) begin
          p_vld_d = 1'b1;
          idx_d   = idx_q + CNT_W'(1);
        end
        if (p_vld_q) begin
          vt_we            = 1'b1;
          vt_wdata.visited = (p_idx_q == src_q);
          vt_wdata.pred    = src_q;
          if (p_idx_q == src_q) begin
            vt_wdata.distance = '0;
          end else if (mat_rdata != '0) begin
            vt_wdata.distance = DIST_W'(mat_rdata);
          end else begin
            vt_wdata.distance = INF_DIST;
          end
        end
        if (phase_done) begin
          idx_d   = '0;
          best_d  = INF_DIST;
          found_d = 1'b0;
          state_d = (n_q == CNT_W'(1)) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (iss_act) begin
          p_vld_d = 1'b1;
          idx_d   = idx_q + CNT_W'(1);
        end
        if (p_vld_q && !vt_rdata.visited && (vt_rdata.distance < best_q)) begin
          best_d     = vt_rdata.distance;
          cur_d      = p_idx_q;
          cur_pred_d = vt_rdata.pred;
          found_d    = 1'b1;
        end
        if (phase_done) begin
          idx_d = '0;
          if (!found_q) begin
            state_d = ST_OUT;
          end else begin
            vt_we             = 1'b1;
            vt_waddr          = cur_q;
            vt_wdata.visited  = 1'b1;
            vt_wdata.distance = best_q;
            vt_wdata.pred     = cur_pred_q;
            state_d           = ST_RELAX;
          end
        end
      end
      ST_RELAX: begin
        mat_raddr = {cur_q, idx_q[VERT_W-1:0]};
        if (iss_act) begin
          p_vld_d = 1'b1;
          idx_d   = idx_q + CNT_W'(1);
        end
        if (p_vld_q && !vt_rdata.visited && (mat_rdata != '0) &&
            (sum_sat < vt_rdata.distance)) begin
          vt_we             = 1'b1;
          vt_wdata.visited  = 1'b0;
          vt_wdata.distance = sum_sat;
          vt_wdata.pred     = cur_q;
        end
        if (phase_done) begin
          idx_d   = '0;
          step_d  = step_q + CNT_W'(1);
          best_d  = INF_DIST;
          found_d = 1'b0;
          if ((step_q + CNT_W'(1)) >= (n_q - CNT_W'(1))) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_OUT: begin
        if (iss_act) begin
          p_vld_d = 1'b1;
          idx_d   = idx_q + CNT_W'(1);
        end
        if (p_vld_q) begin
          res_vld_d  = 1'b1;
          res_idx_d  = p_idx_q;
          res_dist_d = vt_rdata.distance;
          res_pred_d = vt_rdata.pred;
          res_last_d = (CNT_W'(p_idx_q) == (n_q - CNT_W'(1)));
        end
        if (phase_done) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cfg_q     <= VCOUNT_RESET;
      n_q       <= CNT_W'(1);
      idx_q     <= '0;
      p_vld_q   <= 1'b0;
      found_q   <= 1'b0;
      step_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      n_q       <= n_d;
      idx_q     <= idx_d;
      p_vld_q   <= p_vld_d;
      found_q   <= found_d;
      step_q    <= step_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    p_idx_q    <= p_idx_d;
    best_q     <= best_d;
    cur_q      <= cur_d;
    cur_pred_q <= cur_pred_d;
    res_idx_q  <= res_idx_d;
    res_dist_q <= res_dist_d;
    res_pred_q <= res_pred_d;
    res_last_q <= res_last_d;
  end

  assign result_valid_o = res_vld_q;
  assign vertex_index_o = res_idx_q;
  assign distance_o     = res_dist_q;
  assign predecessor_o  = res_pred_q;
  assign last_o         = res_last_q;

`ifndef SYNTHESIS
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_result_from_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_OUT))
    else $error("result beat outside the output pass");

  a_relax_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RELAX && vt_we && iss_act) |-> (vt_waddr != vt_raddr))
    else $error("vertex table write and read collide during relax");

  a_last_with_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("result beat follows the last beat of a run");
`endif

endmodule

`default_nettype wire

@@ sv/ssspd_ram.sv @@
// ----------------------------------------------------------------------------
// ssspd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssspd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
